>>> src/cdq_pkg.sv
// Shared types and constants for the circular deque with read cursor.
package cdq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int RECORD_W_DEF = 64;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_NEXT  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } fsm_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // execute the captured command
    } dp_cmd_t;

endpackage

>>> src/cdq_ctrl.sv
// Controller state machine: sequences capture, execute and result handoff.
module cdq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output cdq_pkg::dp_cmd_t ctl
);
    import cdq_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_stall  = out_stall;
                if (!out_stall)
                begin
                    if (in_valid)
                    begin
                        ctl.load   = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A captured beat is always executed next cycle
    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec)
        else $error("captured beat not executed");

    // Execution always presents a result next cycle
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> out_valid)
        else $error("result not presented after execute");

    // A stalled result stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

endmodule

>>> src/cdq_dp.sv
// Datapath: ring memory, front/count/cursor registers and result registers.
module cdq_dp #(
    parameter int DEPTH    = cdq_pkg::DEPTH_DEF,
    parameter int RECORD_W = cdq_pkg::RECORD_W_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdq_pkg::dp_cmd_t              ctl,
    input  logic [cdq_pkg::CMD_W-1:0]     cmd,
    input  logic [RECORD_W-1:0]           record_in,
    output logic [cdq_pkg::STATUS_W-1:0]  status,
    output logic [RECORD_W-1:0]           record_out,
    output logic [CNT_W-1:0]              count
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

    logic [RECORD_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [RECORD_W-1:0] rec_reg;
    status_t             st_reg, st_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [RECORD_W-1:0] rd_data_reg;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                empty, full;
    logic [IDX_W-1:0]    front_prev, front_inc, cursor_inc, tail_slot, back_slot;
    logic [SUM_W-1:0]    sum, bsum;

    // Ring position arithmetic
    always_comb
    begin
        empty      = (count_reg == '0);
        full       = (count_reg == DEPTH_C);
        front_prev = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
        front_inc  = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
        cursor_inc = (cursor_reg == IDX_LAST) ? '0 : cursor_reg + IDX_W'(1);
        sum        = SUM_W'(front_reg) + SUM_W'(count_reg);
        bsum       = sum - SUM_W'(1);
        tail_slot  = (sum >= DEPTH_S) ? IDX_W'(sum - DEPTH_S) : IDX_W'(sum);
        back_slot  = (bsum >= DEPTH_S) ? IDX_W'(bsum - DEPTH_S) : IDX_W'(bsum);
    end

    // Command decode and state update
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        st_next     = ST_OK;
        rd_ok_next  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;
        unique case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = front_prev;
                    front_next  = front_prev;
                    cursor_next = front_prev;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (empty)
                    begin
                        cursor_next = tail_slot;
                    end
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                    if (cursor_reg == front_reg || count_reg == CNT_W'(1))
                    begin
                        cursor_next = front_inc;
                    end
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (cursor_reg == back_slot || count_reg == CNT_W'(1))
                    begin
                        cursor_next = front_reg;
                    end
                end
            end
            CMD_READ_NEXT:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    rd_ok_next  = 1'b1;
                    cursor_next = (cursor_reg == back_slot) ? front_reg : cursor_inc;
                end
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    // Control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            st_reg     <= ST_OK;
            rd_ok_reg  <= 1'b0;
        end
        else if (ctl.exec)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            st_reg     <= st_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    // Input beat capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            rec_reg <= record_in;
        end
    end

    // Ring memory: one write port, registered read at the cursor
    always_ff @(posedge clk)
    begin
        if (ctl.exec && wr_en)
        begin
            mem[wr_addr] <= rec_reg;
        end
        if (ctl.exec)
        begin
            rd_data_reg <= mem[cursor_reg];
        end
    end

    assign status     = st_reg;
    assign record_out = rd_ok_reg ? rd_data_reg : '0;
    assign count      = count_reg;

    // Fill level never exceeds the ring size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    // One command moves the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> (count_reg == $past(count_reg)
                   || count_reg == $past(count_reg) + CNT_W'(1)
                   || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count changed by more than one");

    // Pointer state only moves on execute
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.exec |=> ($stable(count_reg) && $stable(front_reg) && $stable(cursor_reg)))
        else $error("deque state changed outside execute");

endmodule

>>> src/circular_deque_with_cursor.sv
// Top level of the circular deque with rotating read cursor.
//
// Usage: a bounded double-ended queue of DEPTH records of RECORD_W bits.
// Input channel (in_valid/in_stall) carries one command beat: cmd and
// record_in. Commands: push front, push back, pop front, pop back, read
// next. Output channel (out_valid/out_stall) returns exactly one result
// beat per command: status (ok, empty, full), record_out (record under the
// cursor for a successful read next, else zero) and count after the command.
// Each command is captured, then executed against the ring memory, whose
// read port is registered; the result is presented once execution is done.
// The next command is accepted in the same cycle the current result is
// taken, so a new command is not accepted before the last result is taken.
// While out_stall is high the result holds and in_stall stays high.
// Reset empties the deque and parks front and cursor at slot 0; memory
// contents are not cleared and are never returned before being written.
module circular_deque_with_cursor #(
    parameter int DEPTH    = cdq_pkg::DEPTH_DEF,
    parameter int RECORD_W = cdq_pkg::RECORD_W_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cdq_pkg::CMD_W-1:0]     cmd,
    input  logic [RECORD_W-1:0]           record_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cdq_pkg::STATUS_W-1:0]  status,
    output logic [RECORD_W-1:0]           record_out,
    output logic [CNT_W-1:0]              count
);
    import cdq_pkg::*;

    dp_cmd_t ctl;

    // Sequencer
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Ring and pointers
    cdq_dp #(
        .DEPTH    (DEPTH),
        .RECORD_W (RECORD_W),
        .CNT_W    (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (cmd),
        .record_in  (record_in),
        .status     (status),
        .record_out (record_out),
        .count      (count)
    );

endmodule

>>> tb/circular_deque_with_cursor_test.sv
// Self-checking testbench for the circular deque with rotating read cursor.
`timescale 1ns / 100ps

module circular_deque_with_cursor_test;
    import cdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int RECORD_W = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_CODE_MAX = (1 << CMD_W) - 1;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        status_t st;
        logic [RECORD_W-1:0] rec;
        logic [CNT_W-1:0] cnt;
    } deque_result_t;

    // Traffic mix for a random burst
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CMD_W-1:0] cmd = '0;
    logic [RECORD_W-1:0] record_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [RECORD_W-1:0] record_out;
    logic [CNT_W-1:0] count;

    // Shadow copy of the deque contents and pointers
    logic [RECORD_W-1:0] shadow_ring [DEPTH];
    logic [3:0] shadow_front = '0;
    logic [CNT_W-1:0] shadow_count = '0;
    logic [3:0] shadow_cursor = '0;

    deque_result_t owed_results [$];
    int errors = 0;
    int n_results = 0;
    int n_reads = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_unused = 0;
    bit idle_on = 1'b1;
    int stall_left = 0;

    circular_deque_with_cursor DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .record_in(record_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .record_out(record_out),
        .count(count)
    );

    always #5 clk = ~clk;

    // Apply one command to the shadow deque and return the result it owes
    function automatic deque_result_t deque_apply(logic [CMD_W-1:0] op,
                                                  logic [RECORD_W-1:0] rec);
        deque_result_t res;
        int back;
        int slot;
        logic hit;
        res.st = ST_OK;
        res.rec = '0;
        back = (int'(shadow_front) + int'(shadow_count) + DEPTH - 1) % DEPTH;
        case (op)
            CMD_PUSH_FRONT:
            begin
                if (shadow_count == CNT_W'(DEPTH))
                    res.st = ST_FULL;
                else
                begin
                    shadow_front = 4'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                    shadow_ring[shadow_front] = rec;
                    shadow_count = shadow_count + 1'b1;
                    shadow_cursor = shadow_front;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (shadow_count == CNT_W'(DEPTH))
                    res.st = ST_FULL;
                else
                begin
                    slot = (int'(shadow_front) + int'(shadow_count)) % DEPTH;
                    shadow_ring[slot] = rec;
                    if (shadow_count == 0)
                        shadow_cursor = 4'(slot);
                    shadow_count = shadow_count + 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    hit = (shadow_cursor == shadow_front);
                    shadow_front = 4'((int'(shadow_front) + 1) % DEPTH);
                    shadow_count = shadow_count - 1'b1;
                    if (hit || shadow_count == 0)
                        shadow_cursor = shadow_front;
                end
            end
            CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    hit = (int'(shadow_cursor) == back);
                    shadow_count = shadow_count - 1'b1;
                    if (hit || shadow_count == 0)
                        shadow_cursor = shadow_front;
                end
            end
            CMD_READ_NEXT:
            begin
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.rec = shadow_ring[shadow_cursor];
                    if (int'(shadow_cursor) == back)
                        shadow_cursor = shadow_front;
                    else
                        shadow_cursor = 4'((int'(shadow_cursor) + 1) % DEPTH);
                end
            end
            default:
                n_unused++;
        endcase
        res.cnt = shadow_count;
        return res;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RECORD_W-1:0] rand_record();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd(mix_t mix);
        int r;
        int push_w;
        int pop_w;
        r = $urandom_range(0, 99);
        push_w = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
        pop_w = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 60 : 30;
        if (r < 3)
            return CMD_W'($urandom_range(CMD_CODE_MAX, int'(CMD_READ_NEXT) + 1));
        r = r - 3;
        if (r < push_w)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (r < push_w + pop_w)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        return CMD_READ_NEXT;
    endfunction

    // Output side back-pressure
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Result check first, then predict the beat accepted at this edge
    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: status %0d record %h count %0d",
                             $time, status, record_out, count);
                    errors++;
                end
                else
                begin
                    want = owed_results[0];
                    owed_results.delete(0);
                    n_results++;
                    if (want.st == ST_FULL)
                        n_full++;
                    if (want.st == ST_EMPTY)
                        n_empty++;
                    if (want.rec != 0)
                        n_reads++;
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                    if (record_out !== want.rec)
                    begin
                        $display("%0t: record_out expected %h actual %h",
                                 $time, want.rec, record_out);
                        errors++;
                    end
                    if (count !== want.cnt)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.cnt, count);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                owed_results = {owed_results, deque_apply(cmd, record_in)};
        end
    end

    // Send one command beat; valid is only lowered when a gap precedes it
    task automatic send_beat(input logic [CMD_W-1:0] op, input logic [RECORD_W-1:0] rec);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 1))
            gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        record_in <= rec;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold off the input until every owed result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    task automatic test_empty_deque();
        send_beat(CMD_POP_FRONT, '1);
        send_beat(CMD_POP_BACK, '0);
        send_beat(CMD_READ_NEXT, '1);
        send_beat(CMD_W'(CMD_CODE_MAX), '1);
        wait_for_results();
    endtask

    // Cursor follows pushes, wraps on read, moves off popped entries
    task automatic test_cursor_walk();
        send_beat(CMD_PUSH_BACK, 64'h0123_4567_89AB_CDEF);
        send_beat(CMD_PUSH_FRONT, 64'hFEDC_BA98_7654_3210);
        repeat (3) send_beat(CMD_READ_NEXT, '0);
        send_beat(CMD_POP_BACK, '0);
        send_beat(CMD_POP_FRONT, '0);
        wait_for_results();
    endtask

    task automatic test_full_deque();
        logic [RECORD_W-1:0] rec;
        for (int i = 0; i < DEPTH; i++)
        begin
            rec = (i == 0) ? '0 : (i == 1) ? '1 : {32'hA5A5_5A5A, 32'(i)};
            send_beat((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rec);
        end
        send_beat(CMD_PUSH_FRONT, '1);
        wait_for_results();
    endtask

    // Bursts that swing the fill level between empty and full
    task automatic run_bursts(input int n_items);
        mix_t mix;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            mix = mix_t'($urandom_range(0, 2));
            repeat ($urandom_range(20, 60))
            begin
                send_beat(rand_cmd(mix), rand_record());
                sent++;
                if (sent % 250 == 0)
                    wait_for_results();
            end
        end
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        run_bursts(1000);
        wait_for_results();
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        run_bursts(300);
        wait_for_results();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_deque();
        test_cursor_walk();
        test_full_deque();
        test_random_traffic();
        test_streaming();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d results: %0d nonzero reads, %0d full and %0d empty rejections,",
                 n_results, n_reads, n_full, n_empty);
        $display("%0d unused command codes, %0d mismatching fields", n_unused, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, owed_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
